>>> rtl/core/bfa_pkg.sv
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types and constants for the bitmap frame allocator: request and
// response payloads, action codes and count limits.
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam int FRAME_CAPACITY_DEF = 4096;
  localparam int WORD_BITS_DEF      = 32;

  localparam int ACT_W   = 3;
  localparam int INDEX_W = 12;
  localparam int CNT_W   = 13;

  localparam logic [CNT_W-1:0] COUNT_MAX         = 13'h1FFF;
  localparam logic [CNT_W-1:0] FRAME_COUNT_RESET = 13'd4096;

  // Action codes carried in the request
  typedef enum logic [ACT_W-1:0] {
    ACT_RESERVE  = 3'd0,
    ACT_RELEASE  = 3'd1,
    ACT_TEST     = 3'd2,
    ACT_ALLOCATE = 3'd3,
    ACT_FREE     = 3'd4,
    ACT_RECOUNT  = 3'd5
  } bfa_action_t;

  typedef struct packed {
    logic [ACT_W-1:0]   action;
    logic [INDEX_W-1:0] frame_num;
    logic [CNT_W-1:0]   run_length;
  } bfa_req_t;

  typedef struct packed {
    logic [INDEX_W-1:0] run_base;
    logic               success;
    logic               bit_used;
    logic [CNT_W-1:0]   used_total;
  } bfa_rsp_t;

endpackage

>>> rtl/core/bitmap_frame_allocator_top.sv
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_top
// Bitmap page frame allocator: a used map held in one synchronous memory,
// one word per access, plus a saturating count of used frames.
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+-----------------------
//   in       | input     | in_valid / in_stall   | in_req  (bfa_req_t)
//   out      | output    | out_valid / out_stall | out_rsp (bfa_rsp_t)
//   cfg      | input     | cfg_wr_en             | cfg_wr_data (frame_count)
//
// Reserve, release, test and free pass through one memory read, a write back
// (none for test) and a load of the response register; unknown actions go
// straight to the load. Allocate scans W words (one word per cycle through
// the single read port, up to 128), then marks M words (up to 128). Recount
// reads every word below frame_count (up to 128). Reset is synchronous; map
// words read as all used until first written, so no clearing pass is needed.
// A stalled response holds the engine in its final state; one new request is
// taken while the last response waits.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator_top
  import bfa_pkg::*;
#(
  parameter int FRAME_CAPACITY = FRAME_CAPACITY_DEF,
  parameter int WORD_BITS      = WORD_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  bfa_req_t         in_req,
  output logic             out_valid,
  input  logic             out_stall,
  output bfa_rsp_t         out_rsp,
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data
);

  localparam int MAP_WORDS = (FRAME_CAPACITY + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BW        = $clog2(WORD_BITS);
  localparam int FW        = $clog2(FRAME_CAPACITY) + 1;
  localparam int XW        = ((FW > CNT_W) ? FW : CNT_W) + 1;
  localparam int DSH       = XW + BW;
  localparam longint DM    = ((64'd1 << DSH) + WORD_BITS - 1) / WORD_BITS;

  localparam logic [DSH:0]    DMV   = (DSH+1)'(DM);
  localparam logic [XW-1:0]   WB    = XW'(WORD_BITS);
  localparam logic [XW-1:0]   CAPX  = XW'(FRAME_CAPACITY);
  localparam logic [XW-1:0]   MAXX  = XW'(COUNT_MAX);
  localparam logic [AW-1:0]   LASTA = AW'(MAP_WORDS - 1);
  localparam logic [BW-1:0]   TOPB  = BW'(WORD_BITS - 1);

  // Word number of a frame: multiply by a rounded-up reciprocal
  function automatic logic [XW-1:0] wdiv(input logic [XW-1:0] x);
    logic [XW+DSH:0] p;
    p = (XW+DSH+1)'(x) * (XW+DSH+1)'(DMV);
    return p[DSH +: XW];
  endfunction

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_SRCH = 7'b0000010,
    ST_MRD  = 7'b0000100,
    ST_MARK = 7'b0001000,
    ST_RMW  = 7'b0010000,
    ST_CNT  = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_t;

  state_t state;

  // Configuration and request registers
  logic [CNT_W-1:0]   frame_count;
  logic [ACT_W-1:0]   act;
  logic [XW-1:0]      fidx;
  logic [XW-1:0]      nreg;
  logic [XW-1:0]      lim;
  logic [AW-1:0]      lastw;

  // Walk registers
  logic [AW-1:0]      pw;
  logic [XW-1:0]      pbase;
  logic [XW-1:0]      avail;
  logic [XW-1:0]      s_r;
  logic [XW-1:0]      e_r;
  logic [AW-1:0]      mw;
  logic [AW-1:0]      we_r;
  logic [BW-1:0]      slo;
  logic [BW-1:0]      ehi;
  logic               mfirst;
  logic [CNT_W-1:0]   acc;
  logic [CNT_W-1:0]   used_counter;

  // Pending response fields
  logic [INDEX_W-1:0] r_start;
  logic               r_ok;
  logic               r_bit;

  // Map memory
  logic [WORD_BITS-1:0] mem [MAP_WORDS];
  logic [MAP_WORDS-1:0] wvld;
  logic [WORD_BITS-1:0] rd_data;
  logic                 rd_hit;
  logic [AW-1:0]        rd_addr;
  logic [AW-1:0]        wr_addr;
  logic [WORD_BITS-1:0] wr_data;
  logic                 mem_we;
  logic [WORD_BITS-1:0] word_q;

  logic                 accept;
  logic [XW-1:0]        fc_x;
  logic [XW-1:0]        lim_c;
  logic [XW-1:0]        in_fidx;
  logic [XW-1:0]        in_q;
  logic [XW-1:0]        fq;
  logic [BW-1:0]        fr;
  logic                 idx_ok;
  logic                 bitv;
  logic [WORD_BITS-1:0] onebit;
  logic [WORD_BITS-1:0] bm;
  logic                 hit_any;
  logic [BW-1:0]        j0;
  logic [XW-1:0]        avail_nx;
  logic [XW-1:0]        s_c;
  logic [XW-1:0]        add_sum;
  logic [CNT_W-1:0]     add_sat;
  logic [XW-1:0]        cnt_sum;
  logic [CNT_W-1:0]     cnt_sat;
  logic [XW-1:0]        ws_c;
  logic [XW-1:0]        we_c;
  logic [BW-1:0]        lo;
  logic [BW-1:0]        hi;
  logic [WORD_BITS-1:0] mmask;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign word_q   = rd_hit ? rd_data : '1;

  // Search bound and request word address
  assign fc_x    = XW'(frame_count);
  assign lim_c   = (fc_x > CAPX) ? CAPX : fc_x;
  assign in_fidx = XW'(in_req.frame_num);
  assign in_q    = wdiv(in_fidx);

  // Single-bit access decode
  assign fq     = wdiv(fidx);
  assign fr     = BW'(fidx - fq * WB);
  assign idx_ok = fidx < CAPX;
  assign bitv   = word_q[fr];
  assign onebit = WORD_BITS'(1) << fr;

  // Frames of the current word that lie below the bound
  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      bm[j] = (pbase + XW'(j)) < lim;
    end
  end

  // Find the lowest bit of this word that completes a free run
  always_comb begin
    logic          sn;
    logic [BW-1:0] hk;
    logic [XW-1:0] rl;
    sn      = 1'b0;
    hk      = '0;
    rl      = '0;
    hit_any = 1'b0;
    j0      = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      sn = 1'b0;
      hk = '0;
      for (int k = 0; k <= j; k++) begin
        if (word_q[k]) begin
          sn = 1'b1;
          hk = BW'(k);
        end
      end
      rl = sn ? XW'(BW'(j) - hk) : avail + XW'(j + 1);
      if (bm[j] && (rl >= nreg) && !hit_any) begin
        hit_any = 1'b1;
        j0      = BW'(j);
      end
    end
    avail_nx = sn ? XW'(TOPB - hk) : avail + WB;
  end

  assign s_c     = pbase + XW'(j0) + XW'(1) - nreg;
  assign add_sum = XW'(used_counter) + nreg;
  assign add_sat = (add_sum > MAXX) ? COUNT_MAX : add_sum[CNT_W-1:0];
  assign cnt_sum = XW'(acc) + XW'($countones(word_q & bm));
  assign cnt_sat = (cnt_sum > MAXX) ? COUNT_MAX : cnt_sum[CNT_W-1:0];

  // Run bounds in words
  assign ws_c = wdiv(s_r);
  assign we_c = wdiv(e_r);

  // Mark mask for the current word of the run
  assign lo = mfirst ? slo : '0;
  assign hi = (mw == we_r) ? ehi : TOPB;
  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      mmask[j] = (BW'(j) >= lo) && (BW'(j) <= hi);
    end
  end

  // Read address per state
  always_comb begin
    unique case (state)
      ST_IDLE: begin
        if (in_req.action == ACT_ALLOCATE || in_req.action == ACT_RECOUNT) begin
          rd_addr = '0;
        end else if (in_fidx < CAPX) begin
          rd_addr = in_q[AW-1:0];
        end else begin
          rd_addr = '0;
        end
      end
      ST_SRCH, ST_CNT: rd_addr = (pw == LASTA) ? pw : pw + 1'b1;
      ST_MRD:          rd_addr = ws_c[AW-1:0];
      ST_MARK:         rd_addr = (mw == LASTA) ? mw : mw + 1'b1;
      default:         rd_addr = pw;
    endcase
  end

  // Write port
  always_comb begin
    mem_we  = 1'b0;
    wr_addr = mw;
    wr_data = word_q | mmask;
    if (state == ST_MARK) begin
      mem_we = 1'b1;
    end else if (state == ST_RMW) begin
      wr_addr = fq[AW-1:0];
      wr_data = (act == ACT_RESERVE) ? (word_q | onebit) : (word_q & ~onebit);
      mem_we  = idx_ok && (act == ACT_RESERVE || act == ACT_RELEASE || act == ACT_FREE);
    end
  end

  // Map storage
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // Written flags; an unwritten word reads as all used
  always_ff @(posedge clk) begin
    if (rst) begin
      wvld   <= '0;
      rd_hit <= 1'b0;
    end else begin
      if (mem_we) begin
        wvld[wr_addr] <= 1'b1;
      end
      rd_hit <= wvld[rd_addr];
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= FRAME_COUNT_RESET;
    end else if (cfg_wr_en) begin
      frame_count <= cfg_wr_data;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      used_counter <= '0;
      out_valid    <= 1'b0;
    end else begin
      // Raise the response when loaded, drop it once taken
      if (state == ST_DONE && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (in_req.action == ACT_ALLOCATE) begin
              state <= (in_req.run_length == '0 || lim_c == '0) ? ST_DONE : ST_SRCH;
            end else if (in_req.action == ACT_RECOUNT) begin
              if (lim_c == '0) begin
                used_counter <= '0;
                state        <= ST_DONE;
              end else begin
                state <= ST_CNT;
              end
            end else if (in_req.action == ACT_RESERVE || in_req.action == ACT_RELEASE ||
                         in_req.action == ACT_TEST || in_req.action == ACT_FREE) begin
              state <= ST_RMW;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_RMW: begin
          if (act == ACT_FREE && idx_ok && used_counter != '0) begin
            used_counter <= used_counter - 1'b1;
          end
          state <= ST_DONE;
        end
        ST_SRCH: begin
          if (hit_any) begin
            if (s_c != '0) begin
              used_counter <= add_sat;
              state        <= ST_MRD;
            end else begin
              state <= ST_DONE;
            end
          end else if (pw == lastw) begin
            state <= ST_DONE;
          end
        end
        ST_MRD: begin
          state <= ST_MARK;
        end
        ST_MARK: begin
          if (mw == we_r) begin
            state <= ST_DONE;
          end
        end
        ST_CNT: begin
          if (pw == lastw) begin
            used_counter <= cnt_sat;
            state        <= ST_DONE;
          end
        end
        ST_DONE: begin
          // Hand over once the output register is free
          if (!out_valid || !out_stall) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      act     <= in_req.action;
      fidx    <= in_fidx;
      nreg    <= XW'(in_req.run_length);
      lim     <= lim_c;
      lastw   <= AW'(wdiv(lim_c - XW'(1)));
      pw      <= '0;
      pbase   <= '0;
      avail   <= '0;
      acc     <= '0;
      r_start <= '0;
      r_ok    <= 1'b0;
      r_bit   <= 1'b0;
    end
    if (state == ST_RMW && act == ACT_TEST) begin
      r_bit <= idx_ok && bitv;
    end
    if (state == ST_SRCH) begin
      if (hit_any && s_c != '0) begin
        s_r     <= s_c;
        e_r     <= s_c + nreg - XW'(1);
        r_start <= s_c[INDEX_W-1:0];
        r_ok    <= 1'b1;
      end else if (!hit_any) begin
        pw    <= pw + 1'b1;
        pbase <= pbase + WB;
        avail <= avail_nx;
      end
    end
    if (state == ST_CNT) begin
      acc   <= cnt_sat;
      pw    <= pw + 1'b1;
      pbase <= pbase + WB;
    end
    if (state == ST_MRD) begin
      mw     <= ws_c[AW-1:0];
      we_r   <= we_c[AW-1:0];
      slo    <= BW'(s_r - ws_c * WB);
      ehi    <= BW'(e_r - we_c * WB);
      mfirst <= 1'b1;
    end
    if (state == ST_MARK) begin
      mw     <= mw + 1'b1;
      mfirst <= 1'b0;
    end
    if (state == ST_DONE && (!out_valid || !out_stall)) begin
      out_rsp.run_base   <= r_start;
      out_rsp.success    <= r_ok;
      out_rsp.bit_used   <= r_bit;
      out_rsp.used_total <= used_counter;
    end
  end

  // Checks
  a_write_state : assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == ST_MARK || state == ST_RMW))
    else $error("map write outside mark or read-modify-write");

  a_mark_cont : assert property (@(posedge clk) disable iff (rst)
    (state == ST_MARK && mw != we_r) |=> state == ST_MARK)
    else $error("mark sweep ended before last word");

  a_ok_start : assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_rsp.success) |-> out_rsp.run_base != '0)
    else $error("successful allocate reported at frame zero");

  a_rsp_src : assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_DONE)
    else $error("response loaded outside final state");

  a_srch_ok : assert property (@(posedge clk) disable iff (rst)
    (state == ST_SRCH && hit_any && s_c != '0) |=> state == ST_MRD && r_ok)
    else $error("found run not taken to marking");

endmodule

>>> tb/tb_bitmap_frame_allocator_top.sv
// ----------------------------------------------------------------------------
// tb_bitmap_frame_allocator_top
// Self-checking bench for the bitmap frame allocator. A directed table covers
// reset state, all actions but reserve, count extremes and search corner cases;
// random phases under several frame_count settings follow. Every response is
// checked against fixed values or a bit-accurate model of used map and count.
// ----------------------------------------------------------------------------
module tb_bitmap_frame_allocator_top;
  import bfa_pkg::*;

  localparam int CAPACITY = 4096;
  localparam int WBITS    = 32;
  localparam int NWORDS   = CAPACITY / WBITS;
  localparam int DRAIN    = 400;

  typedef struct packed {
    bfa_req_t req;
    logic     check_fixed;
    bfa_rsp_t fixed_rsp;
  } step_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  bfa_req_t in_req = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  bfa_rsp_t out_rsp;
  logic cfg_wr_en = 1'b0;
  logic [CNT_W-1:0] cfg_wr_data = '0;

  // Model state
  logic [WBITS-1:0] map_model [NWORDS];
  logic [CNT_W-1:0] used_model;
  logic [CNT_W-1:0] frames_model;

  bfa_rsp_t rsp_queue[$];
  logic     fixed_queue[$];
  bfa_rsp_t fixed_vals[$];
  int errors = 0;
  int rsp_seen = 0;
  int alloc_hits = 0;
  bit hold_long = 1'b0;

  bitmap_frame_allocator_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_req(in_req),
    .out_valid(out_valid), .out_stall(out_stall), .out_rsp(out_rsp),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #30000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic map_bit(int f);
    return map_model[f / WBITS][f % WBITS];
  endfunction

  // Lowest run of n clear frames below the bound, 0 when none
  function automatic int run_search(int n);
    int lim;
    int f;
    int avail;
    lim = (frames_model > CAPACITY) ? CAPACITY : frames_model;
    f = 0;
    avail = 0;
    while (f < lim) begin
      if ((f % WBITS) == 0 && map_model[f / WBITS] == '1) begin
        f += WBITS;
        avail = 0;
      end else begin
        if (map_bit(f)) avail = 0;
        else begin
          avail++;
          if (avail == n) return f + 1 - n;
        end
        f++;
      end
    end
    return 0;
  endfunction

  // Apply one request to the model and return the expected response
  function automatic bfa_rsp_t allocator_predict(bfa_req_t r);
    bfa_rsp_t p;
    int s;
    int lim;
    int c;
    int n;
    p = '0;
    n = r.run_length;
    case (r.action)
      ACT_RESERVE: map_model[r.frame_num / WBITS][r.frame_num % WBITS] = 1'b1;
      ACT_RELEASE: map_model[r.frame_num / WBITS][r.frame_num % WBITS] = 1'b0;
      ACT_TEST:    p.bit_used = map_bit(r.frame_num);
      ACT_ALLOCATE: begin
        if (n != 0) begin
          s = run_search(n);
          if (s != 0) begin
            for (int k = 0; k < n; k++) map_model[(s + k) / WBITS][(s + k) % WBITS] = 1'b1;
            used_model = (int'(used_model) + n > int'(COUNT_MAX)) ? COUNT_MAX :
                         CNT_W'(int'(used_model) + n);
            p.run_base = INDEX_W'(s);
            p.success = 1'b1;
          end
        end
      end
      ACT_FREE: begin
        map_model[r.frame_num / WBITS][r.frame_num % WBITS] = 1'b0;
        if (used_model > 0) used_model--;
      end
      ACT_RECOUNT: begin
        lim = (frames_model > CAPACITY) ? CAPACITY : frames_model;
        c = 0;
        for (int f = 0; f < lim; f++) if (map_bit(f) && c < COUNT_MAX) c++;
        used_model = CNT_W'(c);
      end
      default: ;
    endcase
    p.used_total = used_model;
    return p;
  endfunction

  function automatic bfa_rsp_t mk_rsp(int sf, bit ok, bit bu, int tot);
    bfa_rsp_t p;
    p.run_base = INDEX_W'(sf);
    p.success = ok;
    p.bit_used = bu;
    p.used_total = CNT_W'(tot);
    return p;
  endfunction

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 50) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Offer one request and wait for its acceptance
  task automatic send_req(bfa_req_t r, bit chk, bfa_rsp_t fx, bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_req <= r;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    rsp_queue.push_back(allocator_predict(r));
    fixed_queue.push_back(chk);
    fixed_vals.push_back(fx);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (rsp_queue.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_frames(int v);
    cfg_wr_data <= CNT_W'(v);
    cfg_wr_en <= 1'b1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    frames_model = CNT_W'(v);
  endtask

  function automatic bfa_req_t rand_req(int bias);
    bfa_req_t r;
    int k;
    r.frame_num = INDEX_W'($urandom());
    k = $urandom_range(0, 99);
    if (k < 8) r.action = bfa_action_t'($urandom_range(6, 7));
    else if (k < 20) r.action = ACT_RESERVE;
    else if (k < 20 + bias) r.action = ACT_RELEASE;
    else if (k < 45 + bias) r.action = ACT_ALLOCATE;
    else if (k < 70 + bias / 2) r.action = ACT_TEST;
    else if (k < 90) r.action = ACT_FREE;
    else r.action = ACT_RECOUNT;
    k = $urandom_range(0, 99);
    if (k < 70) r.run_length = CNT_W'($urandom_range(1, 8));
    else if (k < 90) r.run_length = CNT_W'($urandom_range(0, 80));
    else r.run_length = CNT_W'($urandom());
    return r;
  endfunction

  // Response checker
  always @(posedge clk) begin
    bfa_rsp_t ex;
    logic fx;
    bfa_rsp_t fv;
    if (!rst && out_valid && !out_stall) begin
      if (rsp_queue.size() == 0) begin
        $error("response with no request outstanding");
        errors++;
      end else begin
        ex = rsp_queue.pop_front();
        fx = fixed_queue.pop_front();
        fv = fixed_vals.pop_front();
        if (fx) ex = fv;
        rsp_seen++;
        if (out_rsp.success) alloc_hits++;
        if (out_rsp.run_base !== ex.run_base) begin
          $error("run_base expected %0d actual %0d", ex.run_base, out_rsp.run_base);
          errors++;
        end
        if (out_rsp.success !== ex.success) begin
          $error("success expected %0d actual %0d", ex.success, out_rsp.success);
          errors++;
        end
        if (out_rsp.bit_used !== ex.bit_used) begin
          $error("bit_used expected %0d actual %0d", ex.bit_used, out_rsp.bit_used);
          errors++;
        end
        if (out_rsp.used_total !== ex.used_total) begin
          $error("used_total expected %0d actual %0d", ex.used_total, out_rsp.used_total);
          errors++;
        end
      end
    end
  end

  // Receiver stall: random gaps, or one long hold-off when asked
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else if (hold_long) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(0, 99) < 25) ? 1'b1 :
                      (($urandom_range(0, 199) == 0) ? 1'b1 : 1'b0);
  end

  step_row_t dir_rows [$];

  task automatic add_row(bfa_action_t a, int fi, int n, bit chk, bfa_rsp_t fx);
    step_row_t s;
    s.req.action = a;
    s.req.frame_num = INDEX_W'(fi);
    s.req.run_length = CNT_W'(n);
    s.check_fixed = chk;
    s.fixed_rsp = fx;
    dir_rows.push_back(s);
  endtask

  initial begin
    bfa_rsp_t z;
    int cfgs [5];
    z = '0;
    for (int w = 0; w < NWORDS; w++) map_model[w] = '1;
    used_model = 0;
    frames_model = FRAME_COUNT_RESET;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table: fixed values where obvious, model elsewhere
    add_row(ACT_TEST, 0, 0, 1, mk_rsp(0, 0, 1, 0));
    add_row(ACT_TEST, 4095, 0, 1, mk_rsp(0, 0, 1, 0));
    add_row(ACT_ALLOCATE, 0, 1, 1, mk_rsp(0, 0, 0, 0));
    add_row(ACT_FREE, 7, 0, 1, mk_rsp(0, 0, 0, 0));
    add_row(ACT_RECOUNT, 0, 0, 1, mk_rsp(0, 0, 0, 4095));
    add_row(ACT_RELEASE, 0, 0, 0, z);
    add_row(ACT_ALLOCATE, 0, 1, 1, mk_rsp(0, 0, 0, 4095));
    add_row(ACT_ALLOCATE, 0, 0, 1, mk_rsp(0, 0, 0, 4095));
    for (int f = 100; f < 110; f++) add_row(ACT_RELEASE, f, 0, 0, z);
    add_row(ACT_ALLOCATE, 0, 4, 0, z);
    add_row(ACT_ALLOCATE, 0, 8, 0, z);
    add_row(ACT_ALLOCATE, 0, 8191, 0, z);
    add_row(ACT_RELEASE, 4095, 0, 0, z);
    add_row(ACT_ALLOCATE, 0, 1, 0, z);
    add_row(ACT_TEST, 4095, 0, 0, z);
    add_row(ACT_FREE, 3000, 0, 0, z);
    add_row(bfa_action_t'(3'd6), 4095, 8191, 0, z);
    add_row(bfa_action_t'(3'd7), 0, 0, 0, z);
    foreach (dir_rows[i]) send_req(dir_rows[i].req, dir_rows[i].check_fixed,
                                   dir_rows[i].fixed_rsp, 1'b0);
    wait_idle();

    // Release random frames so allocations can succeed
    for (int f = 1; f < 600; f++) begin
      bfa_req_t r;
      r = '0;
      r.action = ACT_RELEASE;
      r.frame_num = INDEX_W'($urandom_range(1, 4095));
      send_req(r, 0, z, f % 3 == 0);
    end
    wait_idle();

    // Random phases over several bounds, extremes included
    cfgs = '{4096, 0, 8191, 1, 2077};
    foreach (cfgs[c]) begin
      write_frames(cfgs[c] == 2077 ? $urandom_range(2, 4095) : cfgs[c]);
      for (int i = 0; i < 120; i++) send_req(rand_req(c * 4), 0, z, 1'b1);
      wait_idle();
    end

    // Long receiver hold-off while requests keep coming
    write_frames(4096);
    fork
      begin
        hold_long = 1'b1;
        repeat (500) @(posedge clk);
        hold_long = 1'b0;
      end
      for (int i = 0; i < 20; i++) send_req(rand_req(10), 0, z, 1'b0);
    join
    wait_idle();
    write_frames($urandom_range(33, 4096));
    for (int i = 0; i < 180; i++) send_req(rand_req(15), 0, z, 1'b1);
    wait_idle();

    $display("Covered %0d responses, %0d successful allocations, bounds 0 to 8191.",
             rsp_seen, alloc_hits);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/bfa_pkg.sv
rtl/core/bitmap_frame_allocator_top.sv
tb/tb_bitmap_frame_allocator_top.sv
